@@ design/bed_pkg.sv @@
// Shared types and constants for the button event detector.
`default_nettype none

package bed_pkg;

    localparam int BTN_W     = 8;
    localparam int LONG_W    = 16;
    localparam int REPEAT_W  = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    localparam logic [1:0] REG_INVERT_MASK = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
    localparam logic [1:0] REG_REPEAT      = 2'd2;

    localparam logic [BTN_W-1:0]    INVERT_MASK_RST = '0;
    localparam logic [LONG_W-1:0]   LONG_PRESS_RST  = 16'd100;
    localparam logic [REPEAT_W-1:0] REPEAT_RST      = 16'd50;

    typedef struct packed {
        logic [BTN_W-1:0]    invert_mask;
        logic [LONG_W-1:0]   long_press_ticks;
        logic [REPEAT_W-1:0] repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic [BTN_W-1:0] pressed_bits;
        logic [BTN_W-1:0] down_bits;
        logic [BTN_W-1:0] up_bits;
        logic [BTN_W-1:0] up_short_bits;
        logic [BTN_W-1:0] up_long_bits;
        logic [BTN_W-1:0] repeat_bits;
        logic [BTN_W-1:0] hold_bits;
        logic [BTN_W-1:0] toggle_bits;
    } result_t;

endpackage

`default_nettype wire

@@ design/bed_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module bed_regs
    import bed_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_mask      <= INVERT_MASK_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.repeat_ticks     <= REPEAT_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_INVERT_MASK: cfg_reg.invert_mask      <= pwdata[BTN_W-1:0];
                REG_LONG_PRESS:  cfg_reg.long_press_ticks <= pwdata[LONG_W-1:0];
                REG_REPEAT:      cfg_reg.repeat_ticks     <= pwdata[REPEAT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_INVERT_MASK: prdata = APB_DW'(cfg_reg.invert_mask);
            REG_LONG_PRESS:  prdata = APB_DW'(cfg_reg.long_press_ticks);
            REG_REPEAT:      prdata = APB_DW'(cfg_reg.repeat_ticks);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/bed_core.sv @@
// Edge, timer and toggle logic with per-button sample and toggle registers and one shared press timer.
`default_nettype none

module bed_core
    import bed_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int TIMER_BITS  = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             step,
    input  wire logic [BTN_W-1:0] sample,
    output result_t               res
);

    localparam int CMP_W = ((TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W) + 1;
    localparam logic [BTN_W-1:0] ACTIVE_MASK = (NUM_BUTTONS >= BTN_W) ? {BTN_W{1'b1}} :
        BTN_W'((64'd1 << NUM_BUTTONS) - 64'd1);
    localparam logic [CMP_W-1:0] TMR_MAX = CMP_W'({TIMER_BITS{1'b1}});

    logic [BTN_W-1:0]      previous_sample_reg;
    logic [BTN_W-1:0]      previous_sample_next;
    logic [TIMER_BITS-1:0] press_timer_reg;
    logic [TIMER_BITS-1:0] press_timer_next;
    logic [BTN_W-1:0]      toggle_state_reg;
    logic [BTN_W-1:0]      toggle_state_next;

    logic [BTN_W-1:0] cur;
    logic [BTN_W-1:0] up;
    logic [BTN_W-1:0] down;
    logic             changed;
    logic [CMP_W-1:0] timer_ext;
    logic [CMP_W-1:0] timer_new_ext;
    logic [CMP_W-1:0] long_ext;
    logic [CMP_W-1:0] repeat_ext;
    logic [CMP_W-1:0] cap_full;
    logic [CMP_W-1:0] cap;
    logic             rep_all;
    logic             hold_hit;
    logic             is_long;

    always_comb
    begin
        cur        = (sample ^ cfg.invert_mask) & ACTIVE_MASK;
        up         = ~cur & previous_sample_reg;
        down       = cur & ~previous_sample_reg;
        changed    = (cur != previous_sample_reg);
        timer_ext  = CMP_W'(press_timer_reg);
        long_ext   = CMP_W'(cfg.long_press_ticks);
        repeat_ext = CMP_W'(cfg.repeat_ticks);
        cap_full   = long_ext + CMP_W'(1);
        cap        = (cap_full > TMR_MAX) ? TMR_MAX : cap_full;
        is_long    = (timer_ext >= long_ext);

        if (changed)
        begin
            press_timer_next = '0;
        end
        else if (timer_ext < cap)
        begin
            press_timer_next = press_timer_reg + TIMER_BITS'(1);
        end
        else
        begin
            press_timer_next = press_timer_reg;
        end

        timer_new_ext = CMP_W'(press_timer_next);
        rep_all       = !changed && (timer_new_ext >= repeat_ext);
        hold_hit      = !changed && (timer_new_ext == long_ext);

        toggle_state_next    = toggle_state_reg ^ down;
        previous_sample_next = cur;

        res.pressed_bits  = cur;
        res.down_bits     = down;
        res.up_bits       = up;
        res.up_short_bits = (changed && !is_long) ? up : '0;
        res.up_long_bits  = (changed && is_long) ? up : '0;
        res.repeat_bits   = cur & (down | {BTN_W{rep_all}});
        res.hold_bits     = hold_hit ? cur : '0;
        res.toggle_bits   = toggle_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_sample_reg <= '0;
            press_timer_reg     <= '0;
            toggle_state_reg    <= '0;
        end
        else if (step)
        begin
            previous_sample_reg <= previous_sample_next;
            press_timer_reg     <= press_timer_next;
            toggle_state_reg    <= toggle_state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_change_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (step && changed) |=> (press_timer_reg == '0))
        else $error("Timer not cleared after a change of the sample.");

    a_prev_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (previous_sample_reg == $past(res.pressed_bits)))
        else $error("Stored sample differs from the delivered pressed state.");

    a_toggle_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (toggle_state_reg == $past(res.toggle_bits)))
        else $error("Stored toggle state differs from the delivered toggle bits.");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(press_timer_reg) && $stable(toggle_state_reg)))
        else $error("State changed without a transfer.");
`endif

endmodule

`default_nettype wire

@@ design/button_event_detector.sv @@
// Top level of the button event detector with its transfer pipeline.
// The block takes one sample transfer per clock cycle while the output is not
// stalled and delivers one result transfer for each sample; the sample passes
// through the input register and then the result register. The edge, timer
// and toggle logic between those registers is a single shallow pass, so the
// throughput is one sample per cycle while the result side keeps up. A stalled
// result holds in the result register while one more sample waits in the input
// register. The user must write configuration through the APB-style port only
// while no transfers are in flight; the block itself does not enforce this.
`default_nettype none

module button_event_detector
    import bed_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int TIMER_BITS  = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BTN_W-1:0]  raw_buttons,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [BTN_W-1:0]  pressed_bits,
    output logic      [BTN_W-1:0]  down_bits,
    output logic      [BTN_W-1:0]  up_bits,
    output logic      [BTN_W-1:0]  up_short_bits,
    output logic      [BTN_W-1:0]  up_long_bits,
    output logic      [BTN_W-1:0]  repeat_bits,
    output logic      [BTN_W-1:0]  hold_bits,
    output logic      [BTN_W-1:0]  toggle_bits
);

    cfg_t             cfg;
    result_t          res;
    result_t          result_reg;
    logic             result_valid_reg;
    logic             sample_valid_reg;
    logic [BTN_W-1:0] sample_reg;
    logic             step;
    logic             in_take;

    bed_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bed_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .sample (sample_reg),
        .res    (res)
    );

    assign step     = sample_valid_reg && (!result_valid_reg || !out_stall);
    assign in_stall = sample_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                sample_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                sample_valid_reg <= 1'b0;
            end

            if (step)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= raw_buttons;
        end
        if (step)
        begin
            result_reg <= res;
        end
    end

    assign out_valid     = result_valid_reg;
    assign pressed_bits  = result_reg.pressed_bits;
    assign down_bits     = result_reg.down_bits;
    assign up_bits       = result_reg.up_bits;
    assign up_short_bits = result_reg.up_short_bits;
    assign up_long_bits  = result_reg.up_long_bits;
    assign repeat_bits   = result_reg.repeat_bits;
    assign hold_bits     = result_reg.hold_bits;
    assign toggle_bits   = result_reg.toggle_bits;

endmodule

`default_nettype wire
